// File: design/tpi_pkg.sv
`timescale 1ns / 1ps
// Package for the three-plane intersection block.
// Holds widths, latencies, status codes and register addresses; no dependencies.
package tpi_pkg;
   localparam int FW        = 32;   // input coefficient width
   localparam int PW        = 64;   // 32x32 product
   localparam int CW        = 65;   // cross product component
   localparam int HW        = 33;   // partial operand width
   localparam int MW        = 65;   // partial product width
   localparam int TW        = 98;   // one term of a dot product
   localparam int SW        = 100;  // sum of three terms
   localparam int NW        = 127;  // scaled dividend
   localparam int RW        = 102;  // divider remainder
   localparam int QW        = 48;   // quotient and output width
   localparam int THR_W     = 16;
   localparam int DIV_STEPS = QW;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int FRONT_LAT = 6;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_PAR_PLANES = 2'd1;
   localparam logic [1:0] ST_PAR_LINE   = 2'd2;

   localparam logic [CSR_AW-1:0] ADDR_THRESHOLD = 3'd0;
   localparam logic [THR_W-1:0]  THR_RESET      = 16'd1;
endpackage

// File: design/tpi_csr.sv
`timescale 1ns / 1ps
// Configuration register file holding the parallel threshold.
// Depends on tpi_pkg.
module tpi_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tpi_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [tpi_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [tpi_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output logic [tpi_pkg::THR_W-1:0]     threshold
);
   import tpi_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             hit;

   assign hit        = (csr_paddr == ADDR_THRESHOLD);
   assign csr_pready = 1'b1;
   assign threshold  = thr_ff;
   assign csr_prdata = hit ? {{(CSR_DW-THR_W){1'b0}}, thr_ff} : '0;

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         thr_in = csr_pwdata[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end
endmodule

// File: design/tpi_front.sv
`timescale 1ns / 1ps
// Front pipeline: cross products, split dot products, sums and parallel tests.
// Depends on tpi_pkg; six register stages.
module tpi_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [12*tpi_pkg::FW-1:0]     in_data,
   input  logic [tpi_pkg::THR_W-1:0]     threshold,
   output logic                          out_valid,
   output logic [1:0]                    out_status,
   output logic signed [tpi_pkg::SW-1:0] out_den,
   output logic signed [tpi_pkg::SW-1:0] out_s [3]
);
   import tpi_pkg::*;

   logic signed [FW-1:0] c_in [12];
   logic [FRONT_LAT-1:0] vld_ff;

   logic signed [PW-1:0] prod_ff [18];
   logic signed [FW-1:0] n2_s1_ff [3], d_s1_ff [3];
   logic signed [CW-1:0] x_ff [9];
   logic signed [FW-1:0] n2_s2_ff [3], d_s2_ff [3];
   logic signed [MW-1:0] ph_ff [12], pl_ff [12];
   logic signed [CW-1:0] v3_ff [3];
   logic signed [TW-1:0] t_ff [12];
   logic                 par1_s4_ff;
   logic signed [SW-1:0] sum_ff [4];
   logic                 par1_s5_ff;
   logic signed [SW-1:0] den_ff, s_ff [3];
   logic [1:0]           st_ff;

   logic signed [FW-1:0] n0 [3], n1 [3], n2 [3];
   logic signed [CW-1:0] opa [12];
   logic signed [FW-1:0] opb [12];
   logic                 par1_in;
   logic [CW-1:0]        av;
   logic [SW-1:0]        aden;
   logic [CW-1:0]        thr1;
   logic [SW-1:0]        thr2;

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         c_in[i] = in_data[i*FW +: FW];
      end
      for (int j = 0; j < 3; j++) begin
         n0[j] = c_in[j];
         n1[j] = c_in[4+j];
         n2[j] = c_in[8+j];
      end
   end

   // Operand pairs: den terms v_i*n2_i, then s_i = u_i*d0 + w_i*d1 + v_i*d2.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         opa[i]       = x_ff[i];
         opb[i]       = n2_s2_ff[i];
         opa[3+3*i]   = x_ff[3+i];
         opb[3+3*i]   = d_s2_ff[0];
         opa[4+3*i]   = x_ff[6+i];
         opb[4+3*i]   = d_s2_ff[1];
         opa[5+3*i]   = x_ff[i];
         opb[5+3*i]   = d_s2_ff[2];
      end
   end

   assign thr1 = {{(CW-THR_W-24){1'b0}}, threshold, 24'd0};
   assign thr2 = {{(SW-THR_W-48){1'b0}}, threshold, 48'd0};

   always_comb begin
      logic all_zero, all_small;
      all_zero  = 1'b1;
      all_small = 1'b1;
      for (int i = 0; i < 3; i++) begin
         av = v3_ff[i][CW-1] ? CW'(-v3_ff[i]) : CW'(v3_ff[i]);
         if (v3_ff[i] != '0) all_zero = 1'b0;
         if (av >= thr1) all_small = 1'b0;
      end
      par1_in = all_zero || all_small;
   end

   assign aden = sum_ff[0][SW-1] ? SW'(-sum_ff[0]) : SW'(sum_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FRONT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 1: products for v = n0 x n1, u = n1 x n2, w = n2 x n0.
         prod_ff[0]  <= n0[1] * n1[2];  prod_ff[1]  <= n0[2] * n1[1];
         prod_ff[2]  <= n0[2] * n1[0];  prod_ff[3]  <= n0[0] * n1[2];
         prod_ff[4]  <= n0[0] * n1[1];  prod_ff[5]  <= n0[1] * n1[0];
         prod_ff[6]  <= n1[1] * n2[2];  prod_ff[7]  <= n1[2] * n2[1];
         prod_ff[8]  <= n1[2] * n2[0];  prod_ff[9]  <= n1[0] * n2[2];
         prod_ff[10] <= n1[0] * n2[1];  prod_ff[11] <= n1[1] * n2[0];
         prod_ff[12] <= n2[1] * n0[2];  prod_ff[13] <= n2[2] * n0[1];
         prod_ff[14] <= n2[2] * n0[0];  prod_ff[15] <= n2[0] * n0[2];
         prod_ff[16] <= n2[0] * n0[1];  prod_ff[17] <= n2[1] * n0[0];
         for (int j = 0; j < 3; j++) begin
            n2_s1_ff[j] <= n2[j];
            d_s1_ff[j]  <= c_in[4*j+3];
         end
         // Stage 2: cross product components.
         for (int i = 0; i < 9; i++) begin
            x_ff[i] <= CW'(prod_ff[2*i]) - CW'(prod_ff[2*i+1]);
         end
         n2_s2_ff <= n2_s1_ff;
         d_s2_ff  <= d_s1_ff;
         // Stage 3: each 65x32 product as two 33x32 partial products.
         for (int i = 0; i < 12; i++) begin
            ph_ff[i] <= $signed(opa[i][CW-1:32]) * opb[i];
            pl_ff[i] <= $signed({1'b0, opa[i][31:0]}) * opb[i];
         end
         for (int i = 0; i < 3; i++) begin
            v3_ff[i] <= x_ff[i];
         end
         // Stage 4: recombine the partial products; first parallel test.
         for (int i = 0; i < 12; i++) begin
            t_ff[i] <= (TW'(ph_ff[i]) <<< 32) + TW'(pl_ff[i]);
         end
         par1_s4_ff <= par1_in;
         // Stage 5: three-term sums.
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= SW'(t_ff[3*i]) + SW'(t_ff[3*i+1]) + SW'(t_ff[3*i+2]);
         end
         par1_s5_ff <= par1_s4_ff;
         // Stage 6: second parallel test and status.
         den_ff <= sum_ff[0];
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= sum_ff[i+1];
         end
         if (par1_s5_ff) begin
            st_ff <= ST_PAR_PLANES;
         end else if (sum_ff[0] == '0 || aden < thr2) begin
            st_ff <= ST_PAR_LINE;
         end else begin
            st_ff <= ST_OK;
         end
      end
   end

   assign out_valid  = vld_ff[FRONT_LAT-1];
   assign out_status = st_ff;
   assign out_den    = den_ff;
   assign out_s      = s_ff;
endmodule

// File: design/tpi_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider giving one rounded, saturated Q24.24 coordinate.
// Depends on tpi_pkg; two setup stages and one stage per quotient bit.
module tpi_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [tpi_pkg::SW-1:0] num,
   input  logic signed [tpi_pkg::SW-1:0] den,
   output logic [tpi_pkg::QW-1:0]        coord
);
   import tpi_pkg::*;

   logic [NW-1:0]  n_ff;
   logic [RW-1:0]  d0_ff;
   logic           neg0_ff;
   logic [SW-1:0]  as, ad;

   logic [RW-1:0]  rem_ff [DIV_STEPS+1];
   logic [RW-1:0]  d_ff   [DIV_STEPS+1];
   logic [QW-1:0]  q_ff   [DIV_STEPS+1];
   logic [QW-1:0]  nlo_ff [DIV_STEPS+1];
   logic           neg_ff [DIV_STEPS+1];
   logic           ovf_ff [DIV_STEPS+1];

   logic [RW-1:0]  hi;
   logic [RW-1:0]  pre [DIV_STEPS];

   assign as = num[SW-1] ? SW'(-num) : SW'(num);
   assign ad = den[SW-1] ? SW'(-den) : SW'(den);
   assign hi = RW'(n_ff[NW-1:QW]);

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         pre[k] = {rem_ff[k][RW-2:0], nlo_ff[k][QW-1-k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // The quotient floor((|s|*2^25 + |den|) / (2*|den|)) rounds half away.
         n_ff    <= {2'b00, as, 25'd0} + NW'(ad);
         d0_ff   <= RW'({ad, 1'b0});
         neg0_ff <= (num[SW-1] == den[SW-1]);
         rem_ff[0] <= hi;
         d_ff[0]   <= d0_ff;
         q_ff[0]   <= '0;
         nlo_ff[0] <= n_ff[QW-1:0];
         neg_ff[0] <= neg0_ff;
         ovf_ff[0] <= (hi >= d0_ff);
         for (int k = 0; k < DIV_STEPS; k++) begin
            if (pre[k] >= d_ff[k]) begin
               rem_ff[k+1] <= pre[k] - d_ff[k];
               q_ff[k+1]   <= q_ff[k] | (QW'(1) << (QW-1-k));
            end else begin
               rem_ff[k+1] <= pre[k];
               q_ff[k+1]   <= q_ff[k];
            end
            d_ff[k+1]   <= d_ff[k];
            nlo_ff[k+1] <= nlo_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      logic big;
      big = ovf_ff[DIV_STEPS] || q_ff[DIV_STEPS][QW-1];
      if (neg_ff[DIV_STEPS]) begin
         coord = big ? {1'b1, {(QW-1){1'b0}}} : QW'(-q_ff[DIV_STEPS]);
      end else begin
         coord = big ? {1'b0, {(QW-1){1'b1}}} : q_ff[DIV_STEPS];
      end
   end
endmodule

// File: design/three_plane_intersection.sv
`timescale 1ns / 1ps
// Three-plane intersection point, top level. Depends on tpi_pkg, tpi_csr,
// tpi_front and tpi_div.
// An accepted request passes six front stages, fifty divider stages and one
// output register to its response; one transaction per cycle while no response waits.
// The whole pipeline advances together and holds while a response waits.
// Reset clears all valid bits and sets the threshold to 1.
module three_plane_intersection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // plane0_a, b, c, d, plane1_a, b, c, d, plane2_a, b, c, d; 32 bits each
   input  logic [12*tpi_pkg::FW-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // point_x, point_y, point_z; 48 bits each
   output logic [3*tpi_pkg::QW-1:0]      rsp_tdata,
   // status
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tpi_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [tpi_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [tpi_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import tpi_pkg::*;

   logic                 en;
   logic [THR_W-1:0]     threshold;
   logic                 f_valid;
   logic [1:0]           f_status;
   logic signed [SW-1:0] f_den;
   logic signed [SW-1:0] f_s [3];
   logic [QW-1:0]        coord [3];
   logic [DIV_LAT-1:0]   vld_ff;
   logic [1:0]           st_ff [DIV_LAT];
   logic                 out_vld_ff;
   logic [3*QW-1:0]      out_data_ff;
   logic [1:0]           out_st_ff;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_st_ff;

   tpi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold)
   );

   tpi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_tvalid),
      .in_data    (req_tdata),
      .threshold  (threshold),
      .out_valid  (f_valid),
      .out_status (f_status),
      .out_den    (f_den),
      .out_s      (f_s)
   );

   for (genvar g = 0; g < 3; g++) begin : g_div
      tpi_div u_div (
         .clock (clock),
         .en    (en),
         .num   (f_s[g]),
         .den   (f_den),
         .coord (coord[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[DIV_LAT-2:0], f_valid};
         out_vld_ff <= vld_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= f_status;
         for (int i = 1; i < DIV_LAT; i++) begin
            st_ff[i] <= st_ff[i-1];
         end
         out_st_ff <= st_ff[DIV_LAT-1];
         if (st_ff[DIV_LAT-1] == ST_OK) begin
            out_data_ff <= {coord[2], coord[1], coord[0]};
         end else begin
            out_data_ff <= '0;
         end
      end
   end
endmodule
